FILE: sv/msrc_pkg.sv
// ----------------------------------------------------------------------------
// msrc_pkg
// shared widths, command codes, pin patterns and config types
// ----------------------------------------------------------------------------
package msrc_pkg;

	localparam int SPEED_WIDTH_DEF = 16;
	localparam int CMD_W           = 8;
	localparam int CFG_W           = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int DUTY_W          = 16;
	localparam int PINS_W          = 4;

	localparam logic [CMD_W-1:0] CMD_FWD     = 8'h75;
	localparam logic [CMD_W-1:0] CMD_REV     = 8'h64;
	localparam logic [CMD_W-1:0] CMD_STOP    = 8'h73;
	localparam logic [CMD_W-1:0] CMD_NEUTRAL = 8'h6e;
	localparam logic [CMD_W-1:0] CMD_LEFT    = 8'h6c;
	localparam logic [CMD_W-1:0] CMD_RIGHT   = 8'h72;

	localparam logic [PINS_W-1:0] PINS_OFF   = 4'h0;
	localparam logic [PINS_W-1:0] PINS_FWD   = 4'h5;
	localparam logic [PINS_W-1:0] PINS_REV   = 4'ha;
	localparam logic [PINS_W-1:0] PINS_RIGHT = 4'h6;
	localparam logic [PINS_W-1:0] PINS_LEFT  = 4'h9;

	localparam logic [CFG_W-1:0] MAX_SPEED_RST   = 16'd20000;
	localparam logic [CFG_W-1:0] MIN_SPEED_RST   = 16'd1000;
	localparam logic [CFG_W-1:0] ACCEL_STEP_RST  = 16'd10;
	localparam logic [CFG_W-1:0] COAST_STEP_RST  = 16'd5;
	localparam logic [CFG_W-1:0] BRAKE_STEP_RST  = 16'd30;
	localparam logic [CFG_W-1:0] RIGHT_TURN_RST  = 16'd15000;
	localparam logic [CFG_W-1:0] LEFT_TURN_RST   = 16'd10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_SPEED,
		REG_MIN_SPEED,
		REG_ACCEL_STEP,
		REG_COAST_STEP,
		REG_BRAKE_STEP,
		REG_RIGHT_TURN_SPEED,
		REG_LEFT_TURN_SPEED
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] max_speed;
		logic [CFG_W-1:0] min_speed;
		logic [CFG_W-1:0] accel_step;
		logic [CFG_W-1:0] coast_step;
		logic [CFG_W-1:0] brake_step;
		logic [CFG_W-1:0] right_turn_speed;
		logic [CFG_W-1:0] left_turn_speed;
	} cfg_t;

endpackage

FILE: sv/msrc_cmd_if.sv
// ----------------------------------------------------------------------------
// msrc_cmd_if
// command byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface msrc_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [msrc_pkg::CMD_W-1:0] command_byte;

	modport source (output valid, output command_byte, input ready);
	modport sink (input valid, input command_byte, output ready);
endinterface

FILE: sv/msrc_res_if.sv
// ----------------------------------------------------------------------------
// msrc_res_if
// result channel: duty, motor pins and direction, valid/ready handshake
// ----------------------------------------------------------------------------
interface msrc_res_if;
	logic                        valid;
	logic                        ready;
	logic [msrc_pkg::DUTY_W-1:0] duty;
	logic [msrc_pkg::PINS_W-1:0] motor_pins;
	logic                        moving_reverse;

	modport source (output valid, output duty, output motor_pins, output moving_reverse,
		input ready);
	modport sink (input valid, input duty, input motor_pins, input moving_reverse,
		output ready);
endinterface

FILE: sv/motor_speed_ramp_controller.sv
// ----------------------------------------------------------------------------
// motor_speed_ramp_controller
// command byte driven speed ramp, brake and turn control for an H-bridge pair
// input register at the command transfer, result register when the result slot
//   is free or drained; throughput one command per cycle while res.ready is
//   high, with the combinational state update between the two registers
// unrecognized bytes are dropped without a result
// arst_n clears speed, direction, turning and pins and loads register defaults
// ----------------------------------------------------------------------------
module motor_speed_ramp_controller #(
	parameter int SPEED_WIDTH = msrc_pkg::SPEED_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	msrc_cmd_if.sink                       cmd,
	msrc_res_if.source                     res,
	input  logic                           cfg_we,
	input  logic [msrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [msrc_pkg::CFG_W-1:0]     cfg_wdata
);
	import msrc_pkg::*;

	localparam int XW = ((SPEED_WIDTH > DUTY_W) ? SPEED_WIDTH : DUTY_W) + 1;

	cfg_t cfg;

	logic             valid_s1;
	logic [CMD_W-1:0] cmd_s1;
	logic             adv_s1;

	logic [SPEED_WIDTH-1:0] speed_q;
	logic                   dir_q;
	logic                   turning_q;
	logic [PINS_W-1:0]      pins_q;

	logic                   known;
	logic [SPEED_WIDTH-1:0] speed_nxt;
	logic                   dir_nxt;
	logic                   turning_nxt;
	logic [PINS_W-1:0]      pins_nxt;
	logic [XW-1:0]          speed_x;

	logic              res_valid_q;
	logic [DUTY_W-1:0] duty_q;
	logic [PINS_W-1:0] res_pins_q;
	logic              res_rev_q;

	msrc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	msrc_update #(.SPEED_WIDTH(SPEED_WIDTH)) u_update (
		.cmd         (cmd_s1),
		.cfg         (cfg),
		.speed       (speed_q),
		.dir         (dir_q),
		.turning     (turning_q),
		.pins        (pins_q),
		.known       (known),
		.speed_nxt   (speed_nxt),
		.dir_nxt     (dir_nxt),
		.turning_nxt (turning_nxt),
		.pins_nxt    (pins_nxt)
	);

	assign adv_s1    = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1 <= cmd.command_byte;
		end
	end

	// drive state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q   <= '0;
			dir_q     <= 1'b0;
			turning_q <= 1'b0;
			pins_q    <= PINS_OFF;
		end else if (adv_s1) begin
			speed_q   <= speed_nxt;
			dir_q     <= dir_nxt;
			turning_q <= turning_nxt;
			pins_q    <= pins_nxt;
		end
	end

	// result register
	assign speed_x = XW'(speed_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= known;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && known) begin
			duty_q     <= (speed_x > XW'({DUTY_W{1'b1}})) ? {DUTY_W{1'b1}} : speed_x[DUTY_W-1:0];
			res_pins_q <= pins_nxt;
			res_rev_q  <= dir_nxt;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.duty           = duty_q;
	assign res.motor_pins     = res_pins_q;
	assign res.moving_reverse = res_rev_q;

`ifndef SYNTH
	a_pins_legal: assert property (@(posedge clk) disable iff (!arst_n)
		pins_q == PINS_OFF || pins_q == PINS_FWD || pins_q == PINS_REV ||
		pins_q == PINS_RIGHT || pins_q == PINS_LEFT)
		else $error("pin pattern outside known set");

	a_turn_pins: assert property (@(posedge clk) disable iff (!arst_n)
		turning_q |-> pins_q != PINS_OFF)
		else $error("turning with pins never written");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(speed_q) && $stable(dir_q) && $stable(turning_q))
		else $error("drive state changed without a command");

	a_res_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res.ready && !adv_s1 |=> !res_valid_q)
		else $error("result repeated after transfer");
`endif
endmodule

FILE: sv/msrc_cfg_regs.sv
// ----------------------------------------------------------------------------
// msrc_cfg_regs
// configuration register file with plain write port
// ----------------------------------------------------------------------------
module msrc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [msrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [msrc_pkg::CFG_W-1:0]     cfg_wdata,
	output msrc_pkg::cfg_t                 cfg
);
	import msrc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed        <= MAX_SPEED_RST;
			cfg_q.min_speed        <= MIN_SPEED_RST;
			cfg_q.accel_step       <= ACCEL_STEP_RST;
			cfg_q.coast_step       <= COAST_STEP_RST;
			cfg_q.brake_step       <= BRAKE_STEP_RST;
			cfg_q.right_turn_speed <= RIGHT_TURN_RST;
			cfg_q.left_turn_speed  <= LEFT_TURN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_SPEED:        cfg_q.max_speed        <= cfg_wdata;
				REG_MIN_SPEED:        cfg_q.min_speed        <= cfg_wdata;
				REG_ACCEL_STEP:       cfg_q.accel_step       <= cfg_wdata;
				REG_COAST_STEP:       cfg_q.coast_step       <= cfg_wdata;
				REG_BRAKE_STEP:       cfg_q.brake_step       <= cfg_wdata;
				REG_RIGHT_TURN_SPEED: cfg_q.right_turn_speed <= cfg_wdata;
				REG_LEFT_TURN_SPEED:  cfg_q.left_turn_speed  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

FILE: sv/msrc_update.sv
// ----------------------------------------------------------------------------
// msrc_update
// next drive state for one command: ramp, brake, flip, stop, coast, turn
// ----------------------------------------------------------------------------
module msrc_update #(
	parameter int SPEED_WIDTH = msrc_pkg::SPEED_WIDTH_DEF
) (
	input  logic [msrc_pkg::CMD_W-1:0]  cmd,
	input  msrc_pkg::cfg_t              cfg,
	input  logic [SPEED_WIDTH-1:0]      speed,
	input  logic                        dir,
	input  logic                        turning,
	input  logic [msrc_pkg::PINS_W-1:0] pins,
	output logic                        known,
	output logic [SPEED_WIDTH-1:0]      speed_nxt,
	output logic                        dir_nxt,
	output logic                        turning_nxt,
	output logic [msrc_pkg::PINS_W-1:0] pins_nxt
);
	import msrc_pkg::*;

	localparam int CW = ((SPEED_WIDTH > CFG_W) ? SPEED_WIDTH : CFG_W) + 1;
	localparam logic [CW-1:0] CAP = CW'((64'd1 << SPEED_WIDTH) - 64'd1);

	function automatic logic [CW-1:0] clamp(input logic [CFG_W-1:0] v);
		logic [CW-1:0] e;
		e = CW'(v);
		return (e > CAP) ? CAP : e;
	endfunction

	function automatic logic [CW-1:0] sub_sat(input logic [CW-1:0] a, input logic [CW-1:0] b);
		return (a > b) ? (a - b) : '0;
	endfunction

	logic [CW-1:0] spd;
	logic [CW-1:0] min_e;
	logic [CW-1:0] top;
	logic [CW-1:0] ramp;
	logic [CW-1:0] s_nxt;
	logic          want_rev;

	assign spd      = CW'(speed);
	assign min_e    = CW'(cfg.min_speed);
	assign top      = clamp(cfg.max_speed);
	assign ramp     = spd + CW'(cfg.accel_step);
	assign want_rev = (cmd == CMD_REV);

	always_comb begin
		known       = 1'b1;
		s_nxt       = spd;
		dir_nxt     = dir;
		turning_nxt = turning;
		pins_nxt    = pins;
		case (cmd)
			CMD_FWD, CMD_REV: begin
				if (dir == want_rev) begin
					if (spd >= top || ramp > top) begin
						s_nxt = top;
					end else begin
						s_nxt = ramp;
					end
				end else if (spd > min_e) begin
					s_nxt = sub_sat(spd, CW'(cfg.brake_step));
				end else begin
					dir_nxt  = want_rev;
					pins_nxt = want_rev ? PINS_REV : PINS_FWD;
				end
			end
			CMD_STOP: s_nxt = '0;
			CMD_NEUTRAL: begin
				s_nxt    = (spd > min_e) ? sub_sat(spd, CW'(cfg.coast_step)) : '0;
				pins_nxt = dir ? PINS_REV : PINS_FWD;
				if (turning) begin
					s_nxt       = '0;
					turning_nxt = 1'b0;
				end
			end
			CMD_RIGHT: begin
				pins_nxt = PINS_RIGHT;
				if (spd < min_e) begin
					turning_nxt = 1'b1;
					s_nxt       = clamp(cfg.right_turn_speed);
				end
			end
			CMD_LEFT: begin
				pins_nxt = PINS_LEFT;
				if (spd < min_e) begin
					turning_nxt = 1'b1;
					s_nxt       = clamp(cfg.left_turn_speed);
				end
			end
			default: known = 1'b0;
		endcase
	end

	assign speed_nxt = s_nxt[SPEED_WIDTH-1:0];
endmodule

FILE: tb/sv/tb_motor_speed_ramp_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_speed_ramp_controller
// Self-checking bench for the command driven speed ramp controller. A local
// drive-train predictor follows every accepted command byte and queues the
// expected duty, pin pattern and direction. Each result transfer is checked
// against the oldest entry. Directed sequences cover ramping, braking, direction
// flips, turns, neutral and ignored bytes. Random streams then run under several
// register settings with random idling on both channels, a long result stall
// and a drained pause.
// ----------------------------------------------------------------------------
module tb_motor_speed_ramp_controller;
	import msrc_pkg::*;

	localparam int PIPE_LATENCY = 2;
	localparam int HOLD_CYCLES  = 300;
	localparam int LIMIT_CYCLES = 400000;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic [PINS_W-1:0] pins;
		logic              rev;
	} motor_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	msrc_cmd_if cmd_bus ();
	msrc_res_if res_bus ();

	motor_speed_ramp_controller dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_bus),
		.res      (res_bus),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// predictor state
	cfg_t              model_cfg;
	logic [DUTY_W-1:0] model_speed;
	logic              model_rev;
	logic              model_turning;
	logic [PINS_W-1:0] model_pins;

	motor_result_t pending_motor_results[$];

	bit steady;
	int hold_ticket;
	int commands_sent;
	int bytes_ignored;
	int results_predicted;
	int results_checked;
	int settings_loaded;
	int mismatches;
	int cycle_count;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic void apply_drive(input logic want_rev);
		logic [DUTY_W:0] sum;
		if (model_rev == want_rev) begin
			if (model_speed >= model_cfg.max_speed) begin
				model_speed = model_cfg.max_speed;
			end else begin
				sum = {1'b0, model_speed} + {1'b0, model_cfg.accel_step};
				model_speed = (sum > {1'b0, model_cfg.max_speed}) ? model_cfg.max_speed :
					sum[DUTY_W-1:0];
			end
		end else if (model_speed > model_cfg.min_speed) begin
			model_speed = (model_speed > model_cfg.brake_step) ?
				model_speed - model_cfg.brake_step : '0;
		end else begin
			model_rev  = want_rev;
			model_pins = want_rev ? PINS_REV : PINS_FWD;
		end
	endfunction

	function automatic bit step_drive_train(input logic [CMD_W-1:0] b, output motor_result_t r);
		bit known;
		known = 1'b1;
		case (b)
			CMD_FWD: apply_drive(1'b0);
			CMD_REV: apply_drive(1'b1);
			CMD_STOP: model_speed = '0;
			CMD_NEUTRAL: begin
				if (model_speed > model_cfg.min_speed)
					model_speed = (model_speed > model_cfg.coast_step) ?
						model_speed - model_cfg.coast_step : '0;
				else
					model_speed = '0;
				model_pins = model_rev ? PINS_REV : PINS_FWD;
				if (model_turning) begin
					model_speed   = '0;
					model_turning = 1'b0;
				end
			end
			CMD_RIGHT: begin
				model_pins = PINS_RIGHT;
				if (model_speed < model_cfg.min_speed) begin
					model_turning = 1'b1;
					model_speed   = model_cfg.right_turn_speed;
				end
			end
			CMD_LEFT: begin
				model_pins = PINS_LEFT;
				if (model_speed < model_cfg.min_speed) begin
					model_turning = 1'b1;
					model_speed   = model_cfg.left_turn_speed;
				end
			end
			default: known = 1'b0;
		endcase
		r.duty = model_speed;
		r.pins = model_pins;
		r.rev  = model_rev;
		return known;
	endfunction

	function automatic logic [CMD_W-1:0] next_command();
		int pick;
		pick = $urandom_range(99, 0);
		if (pick < 10) return CMD_W'($urandom_range(255, 0));
		if (pick < 34) return CMD_FWD;
		if (pick < 58) return CMD_REV;
		if (pick < 70) return CMD_NEUTRAL;
		if (pick < 77) return CMD_STOP;
		if (pick < 88) return CMD_LEFT;
		return CMD_RIGHT;
	endfunction

	function automatic cfg_t random_settings(input bit wide);
		cfg_t c;
		if (wide) begin
			c.max_speed        = CFG_W'($urandom_range(65535, 1));
			c.min_speed        = CFG_W'($urandom_range(65535, 0));
			c.accel_step       = CFG_W'($urandom_range(65535, 0));
			c.coast_step       = CFG_W'($urandom_range(65535, 0));
			c.brake_step       = CFG_W'($urandom_range(65535, 0));
			c.right_turn_speed = CFG_W'($urandom_range(65535, 0));
			c.left_turn_speed  = CFG_W'($urandom_range(65535, 0));
		end else begin
			c.max_speed        = CFG_W'($urandom_range(3000, 1));
			c.min_speed        = CFG_W'($urandom_range(c.max_speed, 0));
			c.accel_step       = CFG_W'($urandom_range(400, 0));
			c.coast_step       = CFG_W'($urandom_range(300, 0));
			c.brake_step       = CFG_W'($urandom_range(400, 0));
			c.right_turn_speed = CFG_W'($urandom_range(c.max_speed + 500, 0));
			c.left_turn_speed  = CFG_W'($urandom_range(c.max_speed + 500, 0));
		end
		return c;
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		case (idx)
			REG_MAX_SPEED:        model_cfg.max_speed = v;
			REG_MIN_SPEED:        model_cfg.min_speed = v;
			REG_ACCEL_STEP:       model_cfg.accel_step = v;
			REG_COAST_STEP:       model_cfg.coast_step = v;
			REG_BRAKE_STEP:       model_cfg.brake_step = v;
			REG_RIGHT_TURN_SPEED: model_cfg.right_turn_speed = v;
			REG_LEFT_TURN_SPEED:  model_cfg.left_turn_speed = v;
			default: ;
		endcase
	endtask

	task automatic load_settings(input cfg_t c);
		write_reg(REG_MAX_SPEED, c.max_speed);
		write_reg(REG_MIN_SPEED, c.min_speed);
		write_reg(REG_ACCEL_STEP, c.accel_step);
		write_reg(REG_COAST_STEP, c.coast_step);
		write_reg(REG_BRAKE_STEP, c.brake_step);
		write_reg(REG_RIGHT_TURN_SPEED, c.right_turn_speed);
		write_reg(REG_LEFT_TURN_SPEED, c.left_turn_speed);
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	task automatic send_command(input logic [CMD_W-1:0] b);
		motor_result_t r;
		while (!steady && $urandom_range(99, 0) < 27) begin
			cmd_bus.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_bus.valid        <= 1'b1;
		cmd_bus.command_byte <= b;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
		commands_sent++;
		if (step_drive_train(b, r)) begin
			pending_motor_results.push_back(r);
			results_predicted++;
		end else begin
			bytes_ignored++;
		end
	endtask

	// block is idle once all results are in and a dropped byte has left the pipe
	task automatic wait_idle();
		cmd_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending_motor_results.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	task automatic run_command_phase(input cfg_t c, input int n);
		int target;
		wait_idle();
		load_settings(c);
		target = results_predicted + n;
		while (results_predicted < target) send_command(next_command());
	endtask

	task automatic test_reset_defaults();
		send_command(CMD_FWD);
		send_command(8'h78);
		send_command(8'h00);
		send_command(8'hff);
		send_command(CMD_FWD);
		send_command(CMD_REV);
		send_command(CMD_REV);
		send_command(CMD_STOP);
		send_command(CMD_RIGHT);
		send_command(CMD_REV);
		send_command(CMD_FWD);
		send_command(CMD_LEFT);
		send_command(CMD_NEUTRAL);
		send_command(CMD_NEUTRAL);
		send_command(CMD_FWD);
	endtask

	task automatic test_saturation_and_underflow();
		cfg_t c;
		c = '{max_speed: 16'd100, min_speed: 16'd50, accel_step: 16'd60,
			coast_step: 16'hffff, brake_step: 16'hffff, right_turn_speed: 16'hffff,
			left_turn_speed: 16'd70};
		wait_idle();
		load_settings(c);
		send_command(CMD_FWD);
		send_command(CMD_FWD);
		send_command(CMD_FWD);
		send_command(CMD_RIGHT);
		send_command(CMD_STOP);
		send_command(CMD_RIGHT);
		send_command(CMD_FWD);
		send_command(CMD_REV);
		send_command(CMD_NEUTRAL);
		send_command(CMD_LEFT);
		send_command(CMD_NEUTRAL);
		send_command(CMD_FWD);
		send_command(CMD_NEUTRAL);
	endtask

	task automatic test_extreme_settings();
		cfg_t c;
		c = '{max_speed: 16'hffff, min_speed: 16'd0, accel_step: 16'hffff,
			coast_step: 16'd0, brake_step: 16'hffff, right_turn_speed: 16'hffff,
			left_turn_speed: 16'd0};
		run_command_phase(c, 150);
		c = '{max_speed: 16'd1, min_speed: 16'hffff, accel_step: 16'd0,
			coast_step: 16'hffff, brake_step: 16'd0, right_turn_speed: 16'd0,
			left_turn_speed: 16'hffff};
		run_command_phase(c, 150);
	endtask

	task automatic test_random_settings();
		repeat (4) run_command_phase(random_settings(1'b0), 150);
		run_command_phase(random_settings(1'b1), 150);
	endtask

	task automatic test_backpressure();
		wait_idle();
		load_settings(random_settings(1'b0));
		hold_ticket++;
		steady = 1'b1;
		repeat (60) send_command(next_command());
		steady = 1'b0;
		repeat (40) send_command(next_command());
		cmd_bus.valid <= 1'b0;
		do @(posedge clk); while (pending_motor_results.size() != 0);
		repeat (40) send_command(next_command());
	endtask

	task automatic test_steady_stream();
		steady = 1'b1;
		run_command_phase(random_settings(1'b0), 200);
		steady = 1'b0;
	endtask

	task automatic check_result();
		motor_result_t want;
		if (pending_motor_results.size() == 0) begin
			$error("unexpected result transfer: duty %0d, motor_pins %h, moving_reverse %0b",
				res_bus.duty, res_bus.motor_pins, res_bus.moving_reverse);
			mismatches++;
		end else begin
			want = pending_motor_results.pop_front();
			results_checked++;
			if (res_bus.duty !== want.duty) begin
				$error("duty: expected %0d, actual %0d", want.duty, res_bus.duty);
				mismatches++;
			end
			if (res_bus.motor_pins !== want.pins) begin
				$error("motor_pins: expected %h, actual %h", want.pins, res_bus.motor_pins);
				mismatches++;
			end
			if (res_bus.moving_reverse !== want.rev) begin
				$error("moving_reverse: expected %0b, actual %0b", want.rev,
					res_bus.moving_reverse);
				mismatches++;
			end
		end
	endtask

	initial begin : result_sink
		int hold_left;
		int hold_seen;
		hold_left     = 0;
		hold_seen     = 0;
		res_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_bus.valid && res_bus.ready) check_result();
			if (hold_ticket != hold_seen) begin
				hold_seen = hold_ticket;
				hold_left = HOLD_CYCLES;
			end
			if (!arst_n) begin
				res_bus.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= steady || ($urandom_range(99, 0) >= 27);
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_motor_speed_ramp_controller NOT OK");
		$finish;
	end

	initial begin
		arst_n               = 1'b0;
		cmd_bus.valid        = 1'b0;
		cmd_bus.command_byte = '0;
		cfg_we               = 1'b0;
		cfg_index            = REG_MAX_SPEED;
		cfg_wdata            = '0;
		steady               = 1'b0;
		hold_ticket          = 0;
		commands_sent        = 0;
		bytes_ignored        = 0;
		results_predicted    = 0;
		results_checked      = 0;
		settings_loaded      = 0;
		mismatches           = 0;
		model_cfg.max_speed        = MAX_SPEED_RST;
		model_cfg.min_speed        = MIN_SPEED_RST;
		model_cfg.accel_step       = ACCEL_STEP_RST;
		model_cfg.coast_step       = COAST_STEP_RST;
		model_cfg.brake_step       = BRAKE_STEP_RST;
		model_cfg.right_turn_speed = RIGHT_TURN_RST;
		model_cfg.left_turn_speed  = LEFT_TURN_RST;
		model_speed   = '0;
		model_rev     = 1'b0;
		model_turning = 1'b0;
		model_pins    = PINS_OFF;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_saturation_and_underflow();
		test_extreme_settings();
		test_random_settings();
		test_backpressure();
		test_steady_stream();
		wait_idle();

		$display("run covered %0d command transfers (%0d ignored bytes) over %0d register settings",
			commands_sent, bytes_ignored, settings_loaded);
		$display("%0d results checked, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0)
			$display("tb_motor_speed_ramp_controller OK");
		else
			$display("tb_motor_speed_ramp_controller NOT OK");
		$finish;
	end

endmodule
